// ===== hw/rtl/tmpp_pkg.sv =====
// Shared types and constants of the tile map point picker.
package tmpp_pkg;

   localparam int COORD_W = 20;              // point and origin width
   localparam int SIZE_W = 10;               // tile size width
   localparam int CNT_W = SIZE_W + 1;        // column and row count width
   localparam int IDX_W = 2 * SIZE_W;        // linear tile index width
   localparam int NUM_W = COORD_W + 2;       // dividend magnitude width
   localparam int DIV_W = SIZE_W + 1;        // divisor and remainder width
   localparam int Q_W = NUM_W + 2;           // signed quotient width
   localparam int P_W = 2 * SIZE_W + 5;      // signed product width
   localparam int LANES = 3;
   localparam int CSR_IDX_W = 3;

   // Division lanes: horizontal, vertical and the shifted odd-row column.
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_A = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_W = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_H = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Y = 3'd6;

   localparam logic MODE_RECT = 1'b0;
   localparam logic MODE_ISO = 1'b1;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] acc;   // dividend bits out, quotient bits in
      logic [LANES-1:0][DIV_W-1:0] rem;   // partial remainder
      logic [LANES-1:0]            neg;   // sign of each dividend
   } tmpp_div_type;

endpackage

// ===== hw/rtl/tmpp_if.sv =====
// Request and response channel interfaces of the tile map point picker.
interface tmpp_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tmpp_pkg::COORD_W-1:0] point_x;
   logic signed [tmpp_pkg::COORD_W-1:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink (input valid, point_x, point_y, output ready);
endinterface

interface tmpp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [tmpp_pkg::SIZE_W-1:0]    column;
   logic [tmpp_pkg::SIZE_W-1:0]    row;
   logic [tmpp_pkg::IDX_W-1:0]     tile_index;
   modport source (output valid, hit, column, row, tile_index, input ready);
   modport sink (input valid, hit, column, row, tile_index, output ready);
endinterface

// ===== hw/rtl/tmpp_div_cell.sv =====
// One restoring division step for all three lanes, with its own handshake register.
module tmpp_div_cell (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [tmpp_pkg::LANES-1:0][tmpp_pkg::DIV_W-1:0] divisor,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  tmpp_pkg::tmpp_div_type                         in_data,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output tmpp_pkg::tmpp_div_type                         out_data
);
   import tmpp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   tmpp_div_type data_ff;
   tmpp_div_type data_in;

   // Shift the next dividend bit into the remainder and subtract when it fits.
   always_comb begin
      logic [DIV_W:0] trial;
      data_in = in_data;
      for (int i = 0; i < LANES; i++) begin
         trial = {in_data.rem[i], in_data.acc[i][NUM_W-1]};
         if (trial >= {1'b0, divisor[i]}) begin
            trial = trial - {1'b0, divisor[i]};
            data_in.acc[i] = {in_data.acc[i][NUM_W-2:0], 1'b1};
         end else begin
            data_in.acc[i] = {in_data.acc[i][NUM_W-2:0], 1'b0};
         end
         data_in.rem[i] = trial[DIV_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

// ===== hw/rtl/tile_map_point_picker_top.sv =====
// Top level of the tile map point picker: registers, division chain and tile resolution.
// Pipeline: an accepted request lands in the input stage, then passes 22 division cells
// that each retire one quotient bit, and three resolve stages.
// Throughput: one request per cycle; every stage holds its own valid bit, so a stalled
// response fills the chain stage by stage before the request side is held off.
// Reset (synchronous, active high) empties every stage and restores the registers to
// rectangular mode, 32 by 32 tiles, one column, one row and the origin at zero.
module tile_map_point_picker_top (
   input  logic                              clock,
   input  logic                              reset,
   tmpp_req_if.sink                          req,
   tmpp_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [tmpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tmpp_pkg::COORD_W-1:0]      csr_wdata
);
   import tmpp_pkg::*;

   localparam int STEPS = NUM_W;

   // Configuration registers.
   logic               mode_ff;
   logic [SIZE_W-1:0]  tile_w_ff;
   logic [SIZE_W-1:0]  tile_h_ff;
   logic [CNT_W-1:0]   cols_ff;
   logic [CNT_W-1:0]   rows_ff;
   logic [COORD_W-1:0] org_x_ff;
   logic [COORD_W-1:0] org_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RECT;
         tile_w_ff <= SIZE_W'(32);
         tile_h_ff <= SIZE_W'(32);
         cols_ff   <= CNT_W'(1);
         rows_ff   <= CNT_W'(1);
         org_x_ff  <= '0;
         org_y_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            CSR_TILE_W: tile_w_ff <= csr_wdata[SIZE_W-1:0];
            CSR_TILE_H: tile_h_ff <= csr_wdata[SIZE_W-1:0];
            CSR_COLS:   cols_ff   <= csr_wdata[CNT_W-1:0];
            CSR_ROWS:   rows_ff   <= csr_wdata[CNT_W-1:0];
            CSR_ORG_X:  org_x_ff  <= csr_wdata;
            CSR_ORG_Y:  org_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Counts above the map limit behave as the limit itself.
   logic [CNT_W-1:0] cols_c;
   logic [CNT_W-1:0] rows_c;
   assign cols_c = cols_ff[CNT_W-1] ? {1'b1, {(CNT_W-1){1'b0}}} : cols_ff;
   assign rows_c = rows_ff[CNT_W-1] ? {1'b1, {(CNT_W-1){1'b0}}} : rows_ff;

   logic signed [Q_W-1:0] cols_s;
   logic signed [Q_W-1:0] rows_s;
   assign cols_s = signed'({{(Q_W-CNT_W){1'b0}}, cols_c});
   assign rows_s = signed'({{(Q_W-CNT_W){1'b0}}, rows_c});

   // The odd-row column divides by twice the tile width; the nested truncations of the
   // shifted point collapse into that single truncating division.
   logic [LANES-1:0][DIV_W-1:0] divisor;
   assign divisor[LANE_X] = {1'b0, tile_w_ff};
   assign divisor[LANE_Y] = {1'b0, tile_h_ff};
   assign divisor[LANE_A] = {tile_w_ff, 1'b0};

   // Handshake ready of every stage, from the input stage (0) to the response (last).
   localparam int NSTG = STEPS + 4;
   logic [NSTG-1:0] stg_ready;
   logic [NSTG-1:0] stg_valid;

   // Input stage: origin-relative point, its shifted copy and their magnitudes.
   tmpp_div_type in_ff;
   tmpp_div_type in_in;

   always_comb begin
      logic signed [NUM_W-1:0] dx;
      logic signed [NUM_W-1:0] dy;
      logic signed [NUM_W-1:0] da;
      dx = NUM_W'(req.point_x) - NUM_W'(signed'(org_x_ff));
      dy = NUM_W'(req.point_y) - NUM_W'(signed'(org_y_ff));
      da = (dx <<< 1) - signed'({{(NUM_W-SIZE_W){1'b0}}, tile_w_ff});
      in_in.neg[LANE_X] = dx[NUM_W-1];
      in_in.neg[LANE_Y] = dy[NUM_W-1];
      in_in.neg[LANE_A] = da[NUM_W-1];
      in_in.acc[LANE_X] = dx[NUM_W-1] ? NUM_W'(-dx) : dx;
      in_in.acc[LANE_Y] = dy[NUM_W-1] ? NUM_W'(-dy) : dy;
      in_in.acc[LANE_A] = da[NUM_W-1] ? NUM_W'(-da) : da;
      in_in.rem = '0;
   end

   logic in_valid_ff;
   assign stg_ready[0] = !in_valid_ff || stg_ready[1];
   assign req.ready = stg_ready[0];
   assign stg_valid[0] = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (stg_ready[0]) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0] && req.valid) begin
         in_ff <= in_in;
      end
   end

   // The division chain: cell k retires quotient bit NUM_W-1-k of each lane.
   tmpp_div_type chain [STEPS+1];
   assign chain[0] = in_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      tmpp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (divisor),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k+1]),
         .in_data   (chain[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+2]),
         .out_data  (chain[k+1])
      );
   end

   // Resolve stage one: signed quotients and remainders, and the cross products used by
   // the diamond tests.
   tmpp_div_type dq;
   assign dq = chain[STEPS];

   logic signed [Q_W-1:0] cx_ff, cy_ff, ca_ff;
   logic signed [P_W-1:0] ry2tw_ff, rx2th_ff, twth_ff;
   logic                  top_ff, bot_ff;
   logic                  s1_valid_ff;

   logic signed [Q_W-1:0]    cx_in, cy_in, ca_in;
   logic signed [DIV_W:0]    rx_s, ry_s;
   logic signed [P_W-1:0]    ry2tw_in, rx2th_in, twth_in;
   logic                     top_in, bot_in;

   always_comb begin
      logic signed [Q_W-1:0] mx, my, ma;
      mx = signed'({{(Q_W-NUM_W){1'b0}}, dq.acc[LANE_X]});
      my = signed'({{(Q_W-NUM_W){1'b0}}, dq.acc[LANE_Y]});
      ma = signed'({{(Q_W-NUM_W){1'b0}}, dq.acc[LANE_A]});
      cx_in = dq.neg[LANE_X] ? -mx : mx;
      cy_in = dq.neg[LANE_Y] ? -my : my;
      ca_in = dq.neg[LANE_A] ? -ma : ma;
      // Truncating remainders carry the sign of the dividend.
      rx_s = dq.neg[LANE_X] ? -signed'({1'b0, dq.rem[LANE_X]})
                            : signed'({1'b0, dq.rem[LANE_X]});
      ry_s = dq.neg[LANE_Y] ? -signed'({1'b0, dq.rem[LANE_Y]})
                            : signed'({1'b0, dq.rem[LANE_Y]});
      ry2tw_in = P_W'(ry_s * signed'({2'b0, tile_w_ff})) <<< 1;
      rx2th_in = P_W'(rx_s * signed'({2'b0, tile_h_ff})) <<< 1;
      twth_in = signed'(P_W'({tile_w_ff} * {tile_h_ff}));
      top_in = (ry_s <<< 1) < signed'({2'b0, tile_h_ff});
      bot_in = (ry_s <<< 1) > signed'({2'b0, tile_h_ff});
   end

   assign stg_ready[STEPS+1] = !s1_valid_ff || stg_ready[STEPS+2];
   assign stg_valid[STEPS+1] = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (stg_ready[STEPS+1]) begin
         s1_valid_ff <= stg_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[STEPS+1] && stg_valid[STEPS]) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         ca_ff    <= ca_in;
         ry2tw_ff <= ry2tw_in;
         rx2th_ff <= rx2th_in;
         twth_ff  <= twth_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
      end
   end

   // Resolve stage two: in isometric mode diamond quadrant tests pick the row, then the column
   // is chosen and both are checked against the map.
   logic              hit_in;
   logic [SIZE_W-1:0] col_in, row_in;
   logic              s2_valid_ff;
   logic              hit2_ff;
   logic [SIZE_W-1:0] col2_ff, row2_ff;

   always_comb begin
      logic signed [Q_W-1:0] row_v, col_v, up, even;
      logic                  none, cx0, cy0;
      even = cy_ff <<< 1;
      up = even + Q_W'(1);
      cx0 = (cx_ff == '0);
      cy0 = (cy_ff == '0);
      none = 1'b0;
      row_v = even;
      if (cx_ff < 0 || cx_ff > cols_s) begin
         none = 1'b1;
      end else if (top_ff) begin
         if (ry2tw_ff < twth_ff - rx2th_ff) begin
            none = cx0 || cy0;
            row_v = even - Q_W'(1);
         end else if (ry2tw_ff < rx2th_ff - twth_ff) begin
            none = cy0;
            row_v = even - Q_W'(1);
         end
      end else if (bot_ff) begin
         if (ry2tw_ff - twth_ff > rx2th_ff) begin
            none = cx0 || (up >= rows_s);
            row_v = up;
         end else if (ry2tw_ff - twth_ff > (twth_ff <<< 1) - rx2th_ff) begin
            none = (cx_ff == cols_s) || (up >= rows_s);
            row_v = up;
         end
      end
      if (mode_ff == MODE_RECT) begin
         row_v = cy_ff;
         col_v = cx_ff;
      end else begin
         col_v = row_v[0] ? ca_ff : cx_ff;
      end
      hit_in = (tile_w_ff != '0) && (tile_h_ff != '0)
               && !(mode_ff == MODE_ISO && none)
               && col_v >= 0 && col_v < cols_s && row_v >= 0 && row_v < rows_s;
      col_in = hit_in ? col_v[SIZE_W-1:0] : '0;
      row_in = hit_in ? row_v[SIZE_W-1:0] : '0;
   end

   assign stg_ready[STEPS+2] = !s2_valid_ff || stg_ready[STEPS+3];
   assign stg_valid[STEPS+2] = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (stg_ready[STEPS+2]) begin
         s2_valid_ff <= stg_valid[STEPS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[STEPS+2] && stg_valid[STEPS+1]) begin
         hit2_ff <= hit_in;
         col2_ff <= col_in;
         row2_ff <= row_in;
      end
   end

   // Response register: linear index of the tile; a miss already carries zeros.
   logic              rsp_valid_ff;
   logic              hit_ff;
   logic [SIZE_W-1:0] col_ff, row_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [IDX_W-1:0]  index_in;

   assign index_in = IDX_W'(row2_ff * cols_c) + IDX_W'(col2_ff);

   assign stg_ready[STEPS+3] = !rsp_valid_ff || rsp.ready;
   assign stg_valid[STEPS+3] = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_ready[STEPS+3]) begin
         rsp_valid_ff <= stg_valid[STEPS+2];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[STEPS+3] && stg_valid[STEPS+2]) begin
         hit_ff   <= hit2_ff;
         col_ff   <= col2_ff;
         row_ff   <= row2_ff;
         index_ff <= index_in;
      end
   end

   assign rsp.valid      = stg_valid[STEPS+3];
   assign rsp.hit        = hit_ff;
   assign rsp.column     = col_ff;
   assign rsp.row        = row_ff;
   assign rsp.tile_index = index_ff;
endmodule
